/* rtl/assert_macros.svh */
// Assertion macros shared by the DES RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/des_pkg.sv */
// DES package: permutation tables, S-boxes and round helper functions.
// No dependencies.
package des_pkg;

    localparam int NumRounds = 16;

    typedef logic [63:0] block_t;
    typedef logic [47:0] rkey_t;
    typedef logic [27:0] half28_t;

    // Bit 1 of the standard is the MSB of each word.
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [7:0] t [64];
        logic [63:0] y;
        t = '{8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,
              8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
              8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,
              8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
              8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,
              8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
              8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,
              8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};
        for (int i = 0; i < 64; i++)
            y[63-i] = x[64-int'(t[i])];
        return y;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [7:0] t [64];
        logic [63:0] y;
        t = '{8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,
              8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
              8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,
              8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
              8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,
              8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
              8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,
              8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};
        for (int i = 0; i < 64; i++)
            y[63-i] = x[64-int'(t[i])];
        return y;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [7:0] t [56];
        logic [55:0] y;
        t = '{8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,
              8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,
              8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
              8'd60,8'd52,8'd44,8'd36,8'd63,8'd55,8'd47,8'd39,
              8'd31,8'd23,8'd15,8'd7,8'd62,8'd54,8'd46,8'd38,
              8'd30,8'd22,8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,
              8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};
        for (int i = 0; i < 56; i++)
            y[55-i] = x[64-int'(t[i])];
        return y;
    endfunction

    function automatic rkey_t perm_pc2(input logic [55:0] x);
        logic [7:0] t [48];
        rkey_t y;
        t = '{8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
              8'd23,8'd19,8'd12,8'd4,8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
              8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
              8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};
        for (int i = 0; i < 48; i++)
            y[47-i] = x[56-int'(t[i])];
        return y;
    endfunction

    // Total left rotation after round n (0-based), from 1,1,2,2,2,2,2,2,1,2,...
    function automatic logic [4:0] rot_total(input logic [3:0] n);
        logic [4:0] t [16];
        t = '{5'd1,5'd2,5'd4,5'd6,5'd8,5'd10,5'd12,5'd14,
              5'd15,5'd17,5'd19,5'd21,5'd23,5'd25,5'd27,5'd28};
        return t[n];
    endfunction

    function automatic half28_t rotl28(input half28_t x, input logic [4:0] s);
        logic [55:0] d;
        d = {x, x} << s;
        return d[55:28];
    endfunction

    function automatic logic [3:0] sbox(input logic [2:0] b, input logic [5:0] six);
        logic [3:0] t [8][64];
        t = '{
         '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
           4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
           4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
           4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
         '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
           4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
           4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
           4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
         '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
           4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
           4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
           4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
         '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
           4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
           4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
           4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
         '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
           4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
           4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
           4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
         '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
           4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
           4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
           4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
         '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
           4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
           4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
           4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
         '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
           4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
           4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
           4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};
        return t[b][{six[5], six[0], six[4:1]}];
    endfunction

    // Feistel f: E, key mix, S-boxes, P.
    function automatic logic [31:0] feistel(input logic [31:0] r, input rkey_t k);
        logic [7:0] et [48];
        logic [7:0] pt [32];
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] p;
        et = '{8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
               8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
               8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
               8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};
        pt = '{8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,
               8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
               8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,
               8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};
        for (int i = 0; i < 48; i++)
            e[47-i] = r[32-int'(et[i])];
        e = e ^ k;
        for (int j = 0; j < 8; j++)
            s[31-4*j -: 4] = sbox(3'(j), e[47-6*j -: 6]);
        for (int i = 0; i < 32; i++)
            p[31-i] = s[32-int'(pt[i])];
        return p;
    endfunction

endpackage

/* rtl/des_block_cipher_core.sv */
// DES cipher core top level: key register, IP, sixteen round stages, FP.
// Depends on des_pkg, des_round and assert_macros.svh.

// DES encrypt/decrypt of one 64-bit block per item. Each of the sixteen
// Feistel rounds is its own register stage, so one item enters every cycle
// unless the output stalls, and a result leaves after all sixteen round
// registers (IP and FP are wires around the first and last round). The
// whole pipeline advances together: it moves whenever the output stage is
// empty or being taken, so a stall at the output freezes every stage and
// nothing is lost or repeated. Round keys are derived per stage from the
// PC1 halves of cipher_key; write the key only while no item is in flight.
// decrypt_mode travels with each item and picks the round key order.
module des_block_cipher_core
    import des_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_block,
    input  logic        decrypt_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_block
);
`include "assert_macros.svh"

    logic [63:0] cipher_key_reg;
    logic [55:0] pc1_key;
    logic        advance;

    logic        v [NumRounds+1];
    logic [63:0] lr [NumRounds+1];
    logic        d [NumRounds+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cipher_key_reg <= '0;
        else if (cfg_we)
            cipher_key_reg <= cfg_wdata;
    end

    assign pc1_key = perm_pc1(cipher_key_reg);

    // Global advance: last stage empty or consumed.
    assign advance  = !v[NumRounds] || out_ready;
    assign in_ready = advance;

    assign v[0]  = in_valid;
    assign lr[0] = perm_ip(data_block);
    assign d[0]  = decrypt_mode;

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        des_round #(.RoundIdx(g)) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (v[g]),
            .in_lr     (lr[g]),
            .in_dec    (d[g]),
            .key_c     (pc1_key[55:28]),
            .key_d     (pc1_key[27:0]),
            .out_valid (v[g+1]),
            .out_lr    (lr[g+1]),
            .out_dec   (d[g+1])
        );
    end

    // Final swap of halves, then FP.
    assign out_valid    = v[NumRounds];
    assign result_block = perm_fp({lr[NumRounds][31:0], lr[NumRounds][63:32]});

    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(result_block), "stalled result changed")
    `ASSERT_IMPL(a_ready_on_empty, clk, rst_n, !out_valid, in_ready,
                 "not ready with empty output")
    `ASSERT_NEXT(a_flow, clk, rst_n, in_valid && in_ready,
                 g_round[0].u_round.out_valid, "accepted item lost at stage one")
endmodule

/* rtl/des_round.sv */
// One DES pipeline stage: a Feistel round with its own round key.
// Depends on des_pkg.
module des_round
    import des_pkg::*;
#(
    parameter int RoundIdx = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        in_valid,
    input  logic [63:0] in_lr,
    input  logic        in_dec,
    input  half28_t     key_c,
    input  half28_t     key_d,
    output logic        out_valid,
    output logic [63:0] out_lr,
    output logic        out_dec
);
    logic [3:0] rnd_enc;
    logic [3:0] rnd_sel;
    rkey_t      rkey;
    logic       valid_reg;
    logic       dec_reg;
    logic [63:0] lr_reg;
    logic [63:0] lr_next;

    assign rnd_enc = 4'(RoundIdx);
    assign rnd_sel = in_dec ? (4'd15 - rnd_enc) : rnd_enc;
    // Round key from PC1 halves by total rotation, then PC2.
    assign rkey = perm_pc2({rotl28(key_c, rot_total(rnd_sel)),
                            rotl28(key_d, rot_total(rnd_sel))});
    assign lr_next = {in_lr[31:0], in_lr[63:32] ^ feistel(in_lr[31:0], rkey)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lr_reg  <= lr_next;
            dec_reg <= in_dec;
        end
    end

    assign out_valid = valid_reg;
    assign out_lr    = lr_reg;
    assign out_dec   = dec_reg;
endmodule
